### rtl/rotation_invariant_lbp_defines.svh
// ----------------------------------------------------------------------------
// Rotation-invariant LBP assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ROTATION_INVARIANT_LBP_DEFINES_SVH
`define ROTATION_INVARIANT_LBP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RILBP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotation_invariant_lbp: property failed");

// next-cycle implication, quiet during reset
`define RILBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotation_invariant_lbp: property failed");

// next-cycle implication, checked through reset as well
`define RILBP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rotation_invariant_lbp: property failed");

`endif

### rtl/rilbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation-invariant LBP package
// Field widths, register indexes and the rotation minimum function.
// ----------------------------------------------------------------------------
package rilbp_pkg;

  localparam int PIXEL_W     = 8;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int ROW_W       = 12;
  localparam int SIDE_MIN    = 3;
  localparam int HEIGHT_MAX  = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd64;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd64;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // smallest of the eight circular left rotations
  function automatic pixel_t rotation_min(input pixel_t code);
    pixel_t cur;
    pixel_t best;
    cur  = code;
    best = code;
    for (int k = 1; k < PIXEL_W; k++) begin
      cur = {cur[PIXEL_W-2:0], cur[PIXEL_W-1]};
      if (cur < best) begin
        best = cur;
      end
    end
    return best;
  endfunction

endpackage

### rtl/rotation_invariant_lbp.sv
`timescale 1ns / 1ps
// One pixel is taken per clock while the result side is not stalled; the pattern for the
// centre one row and one column behind is registered in s1 and then in the output
// register after the pixel that completes its window is accepted. The line memory read
// is registered; the memory holds both previous rows side by side, is read at the current
// column on acceptance and is written back with the shifted pair when s1 advances. Border
// pixels give no result; row_last and frame_last mark the end of each interior row and of
// the frame. A width or height write restarts the frame at row zero, column zero. No pass
// clears the line memory; its contents reach no result before two full rows are written.
// ----------------------------------------------------------------------------
// Rotation-invariant LBP top level
// Line memory, 3x3 window and rotation-minimum pattern output.
// ----------------------------------------------------------------------------
module rotation_invariant_lbp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rilbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rilbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [rilbp_pkg::PIXEL_W-1:0]     pixel,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [rilbp_pkg::PIXEL_W-1:0]     pattern_code,
  output logic                              row_last,
  output logic                              frame_last
);
  import rilbp_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic row_end;
    logic frame_end;
  } stage_ctl_t;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [AW-1:0]           col_last;
  logic [ROW_W-1:0]        row_last_idx;
  logic [31:0]             width_clamp;
  logic [31:0]             height_clamp;

  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;

  logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_W-1:0] rd_data;

  stage_ctl_t    s1;
  pixel_t        s1_px;
  logic [AW-1:0] s1_col;

  pixel_t win_top0, win_mid0, win_bot0;
  pixel_t win_top1, win_mid1, win_bot1;

  pixel_t rd_top;
  pixel_t rd_mid;
  pixel_t code;

  logic pixel_accept;
  logic out_free;
  logic s1_advance;
  logic cfg_hit;

  assign rd_top = rd_data[2*PIXEL_W-1:PIXEL_W];
  assign rd_mid = rd_data[PIXEL_W-1:0];

  assign cfg_hit = cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    width_clamp = 32'(image_width);
    if (width_clamp < 32'(SIDE_MIN)) begin
      width_clamp = 32'(SIDE_MIN);
    end else if (width_clamp > 32'(MAX_WIDTH)) begin
      width_clamp = 32'(MAX_WIDTH);
    end
    height_clamp = 32'(image_height);
    if (height_clamp < 32'(SIDE_MIN)) begin
      height_clamp = 32'(SIDE_MIN);
    end else if (height_clamp > 32'(HEIGHT_MAX)) begin
      height_clamp = 32'(HEIGHT_MAX);
    end
    col_last     = AW'(width_clamp - 32'd1);
    row_last_idx = ROW_W'(height_clamp - 32'd1);
  end

  assign out_free     = !result_valid || result_ready;
  assign s1_advance   = s1.valid && (!s1.emit || out_free);
  assign pixel_ready  = !s1.valid || s1_advance;
  assign pixel_accept = pixel_valid && pixel_ready;

  always_comb begin
    code = {win_top1 >= win_mid0, win_top0 >= win_mid0, rd_top >= win_mid0,
            rd_mid >= win_mid0, s1_px >= win_mid0, win_bot0 >= win_mid0,
            win_bot1 >= win_mid0, win_mid1 >= win_mid0};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (pixel_accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last_idx) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // line memory: read on transfer, write back the shifted pair when s1 advances
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      rd_data <= line_mem[col];
    end
    if (s1_advance) begin
      line_mem[s1_col] <= {rd_mid, s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (pixel_accept) begin
      s1.valid     <= 1'b1;
      s1.emit      <= (row >= ROW_W'(2)) && (col >= AW'(2));
      s1.row_end   <= (col == col_last);
      s1.frame_end <= (col == col_last) && (row == row_last_idx);
    end else if (s1_advance) begin
      s1.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_px  <= pixel;
      s1_col <= col;
    end
  end

  // 3x3 window: shift one column per advance
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      win_top0 <= '0;
      win_mid0 <= '0;
      win_bot0 <= '0;
      win_top1 <= '0;
      win_mid1 <= '0;
      win_bot1 <= '0;
    end else if (s1_advance) begin
      win_top1 <= win_top0;
      win_mid1 <= win_mid0;
      win_bot1 <= win_bot0;
      win_top0 <= rd_top;
      win_mid0 <= rd_mid;
      win_bot0 <= s1_px;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_advance && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_advance && s1.emit) begin
      pattern_code <= rotation_min(code);
      row_last     <= s1.row_end;
      frame_last   <= s1.frame_end;
    end
  end

endmodule

### rtl/rilbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation-invariant LBP port checker
// Watches the top-level ports and flags flow and marker slips.
// ----------------------------------------------------------------------------
`include "rotation_invariant_lbp_defines.svh"

module rilbp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pixel_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [rilbp_pkg::PIXEL_W-1:0] pattern_code,
  input logic                          row_last,
  input logic                          frame_last
);
  import rilbp_pkg::*;

  `RILBP_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(pattern_code) && $stable(row_last) && $stable(frame_last))
  `RILBP_ASSERT_IMPLY(a_frame_ends_row, clk, rst, result_valid && frame_last, row_last)
  `RILBP_ASSERT_IMPLY(a_ready_when_out_empty, clk, rst, !result_valid, pixel_ready)
  `RILBP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !result_valid)

endmodule

bind rotation_invariant_lbp rilbp_checker u_rilbp_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_ready  (pixel_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .pattern_code (pattern_code),
  .row_last     (row_last),
  .frame_last   (frame_last)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation-invariant LBP testbench
// Streams pixels through the block under valid/ready with random gaps and
// stalls on both sides and predicts each pattern code, row end and frame end
// from a behavioural window model. A reset-size stream comes first, then a
// short table of 3x3 frames, odd and extreme sizes, random sizes and content.
// ----------------------------------------------------------------------------
module tb;
  import rilbp_pkg::*;

  localparam int LINE_DEPTH   = 1024;
  localparam int PIPE_SETTLE  = 4;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1325;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

  typedef struct packed {
    pixel_t code;
    logic   row_end;
    logic   frame_end;
  } lbp_result_t;

  typedef struct packed {
    pixel_t      px;
    bit          typed;
    lbp_result_t want;
  } directed_row_t;

  localparam lbp_result_t NO_PATTERN = '0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_ready;
  pixel_t                 pixel = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  pixel_t                 pattern_code;
  logic                   row_last;
  logic                   frame_last;

  // window model state
  logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  pixel_t                  upper_row [LINE_DEPTH];
  pixel_t                  lower_row [LINE_DEPTH];
  pixel_t                  win [6];
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;

  lbp_result_t awaited_patterns [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  directed_row_t directed_rows [27] = '{
    '{8'd100, 1'b0, NO_PATTERN}, '{8'd100, 1'b0, NO_PATTERN}, '{8'd100, 1'b0, NO_PATTERN},
    '{8'd100, 1'b0, NO_PATTERN}, '{8'd100, 1'b0, NO_PATTERN}, '{8'd100, 1'b0, NO_PATTERN},
    '{8'd100, 1'b0, NO_PATTERN}, '{8'd100, 1'b0, NO_PATTERN},
    '{8'd100, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{8'd0, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN},
    '{8'd0, 1'b0, NO_PATTERN}, '{8'd255, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN},
    '{8'd0, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN},
    '{8'd0, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{8'd200, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN},
    '{8'd0, 1'b0, NO_PATTERN}, '{8'd128, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN},
    '{8'd0, 1'b0, NO_PATTERN}, '{8'd0, 1'b0, NO_PATTERN},
    '{8'd0, 1'b1, '{8'h01, 1'b1, 1'b1}}
  };

  rotation_invariant_lbp #(
    .MAX_WIDTH(LINE_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pattern_code (pattern_code),
    .row_last     (row_last),
    .frame_last   (frame_last)
  );

  always #10 clk = ~clk;

  function automatic int unsigned eff_width();
    if (width_reg < SIDE_MIN) return SIDE_MIN;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < SIDE_MIN) return SIDE_MIN;
    if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
    return height_reg;
  endfunction

  function automatic pixel_t min_rotation(input pixel_t code);
    pixel_t best;
    pixel_t rot;
    best = code;
    for (int k = 1; k < 8; k++) begin
      rot = (code << k) | (code >> (8 - k));
      if (rot < best) best = rot;
    end
    return best;
  endfunction

  function automatic bit advance_lbp(input pixel_t px, output lbp_result_t res);
    int unsigned ew;
    int unsigned eh;
    pixel_t      above2;
    pixel_t      above1;
    pixel_t      centre;
    pixel_t      ring [8];
    pixel_t      code;
    bit          made;
    ew = eff_width();
    eh = eff_height();
    made = 1'b0;
    res = NO_PATTERN;
    if (col_pos >= ew) col_pos = 0;
    if (row_pos >= eh) row_pos = 0;
    above2 = upper_row[col_pos];
    above1 = lower_row[col_pos];
    upper_row[col_pos] = above1;
    lower_row[col_pos] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      centre = win[1];
      ring = '{win[3], win[0], above2, above1, px, win[2], win[5], win[4]};
      for (int k = 0; k < 8; k++) code[7-k] = (ring[k] >= centre);
      res.code = min_rotation(code);
      res.row_end = (col_pos == ew - 1);
      res.frame_end = res.row_end && (row_pos == eh - 1);
      made = 1'b1;
    end
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = above2;
    win[1] = above1;
    win[2] = px;
    if (col_pos + 1 >= ew) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= eh) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return made;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t pick_pixel(input pixel_t base);
    int v;
    case ($urandom_range(0, 4))
      0, 1: return pixel_t'($urandom_range(0, 255));
      2: begin
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pixel_t'(v);
      end
      3: return base;
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic push_pixel(input pixel_t px, input bit typed, input lbp_result_t want);
    lbp_result_t res;
    int          gap;
    pixel_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    if (advance_lbp(px, res)) awaited_patterns.push_back(typed ? want : res);
    gap = gap_len();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (awaited_patterns.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
        if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
        else height_reg = val[HEIGHT_REG_W-1:0];
        col_pos = 0;
        row_pos = 0;
        for (int k = 0; k < 6; k++) win[k] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic set_registers(input bit do_w, input logic [CFG_DATA_W-1:0] w_val,
                               input bit do_h, input logic [CFG_DATA_W-1:0] h_val);
    settle();
    if (do_w) write_register(REG_IMAGE_WIDTH, w_val);
    if (do_h) write_register(REG_IMAGE_HEIGHT, h_val);
    cfg_write <= 1'b0;
  endtask

  task automatic run_stream(input int n, input bit pressure);
    pixel_t base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      if (pressure && $urandom_range(0, 149) == 0) begin
        pixel_valid <= 1'b0;
        drain();
      end
      push_pixel(pick_pixel(base), 1'b0, NO_PATTERN);
      if ($urandom_range(0, 31) == 0) base = $urandom_range(0, 255);
    end
    pixel_valid <= 1'b0;
  endtask

  task automatic check_pattern();
    lbp_result_t want;
    if (awaited_patterns.size() == 0) begin
      $display("%0t: pattern_code expected none, actual %0d", $time, pattern_code);
      mismatches++;
    end else begin
      want = awaited_patterns.pop_front();
      if (pattern_code !== want.code) begin
        $display("%0t: pattern_code expected %0d, actual %0d", $time, want.code,
                 pattern_code);
        mismatches++;
      end
      if (row_last !== want.row_end) begin
        $display("%0t: row_last expected %0b, actual %0b", $time, want.row_end, row_last);
        mismatches++;
      end
      if (frame_last !== want.frame_end) begin
        $display("%0t: frame_last expected %0b, actual %0b", $time, want.frame_end,
                 frame_last);
        mismatches++;
      end
    end
  endtask

  // result side: random stalls unless in a calm stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) check_pattern();
      if (calm) begin
        result_ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (result_ready) begin
        stall_left = gap_len();
        if (stall_left > 0) result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        stall_left = $urandom_range(0, 12);
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int                    random_items;
    int                    n;
    int                    r;
    int                    sel;
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;
    random_items = 0;
    for (int k = 0; k < LINE_DEPTH; k++) begin
      upper_row[k] = '0;
      lower_row[k] = '0;
    end
    for (int k = 0; k < 6; k++) win[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset sizes
    run_stream(2 * 64 + 70, 1'b0);

    set_registers(1'b1, 13'd3, 1'b1, 13'd3);
    for (int i = 0; i < $size(directed_rows); i++) begin
      push_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
    end
    pixel_valid <= 1'b0;

    // extreme and clamped sizes
    set_registers(1'b1, 13'd0, 1'b1, 13'd8191);
    run_stream(40, 1'b1);
    set_registers(1'b1, 13'd1, 1'b1, 13'd2);
    run_stream(30, 1'b1);

    // writes to unmapped indexes leave the frame running
    settle();
    write_register(REG_SPARE_LOW, CFG_DATA_W'($urandom));
    write_register(REG_SPARE_HIGH, CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
    run_stream(30, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) w_val = $urandom_range(3, 12);
      else if (r < 95) w_val = $urandom_range(13, 40);
      else w_val = $urandom_range(0, 2);
      w_val[CFG_DATA_W-1:WIDTH_REG_W] = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) h_val = $urandom_range(0, 2);
      else h_val = $urandom_range(3, 8);
      sel = $urandom_range(0, 3);
      calm = ($urandom_range(0, 4) == 0);
      set_registers(sel != 3, w_val, sel != 2, h_val);
      n = $urandom_range(1, 2) * eff_width() * eff_height()
          + $urandom_range(0, eff_width() * eff_height());
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      run_stream(n, 1'b1);
      random_items += n;
    end

    drain();
    calm = 1'b1;
    repeat (PIPE_SETTLE * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rilbp_pkg.sv
rtl/rotation_invariant_lbp.sv
rtl/rilbp_checker.sv
bench/tb.sv
